// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLSRNG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clsrng assertion failed");

// next-cycle implication
`define CLSRNG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clsrng assertion failed");

`endif

// ===== rtl/clsrng_pkg.sv =====
// ----------------------------------------------------------------------------
// clsrng_pkg
// Types, constants and the modular fold shared by the shuffled combined RNG.
// ----------------------------------------------------------------------------
package clsrng_pkg;

  localparam int unsigned DEFAULT_TABLE_SIZE = 32;

  typedef logic [30:0] val_t;
  typedef logic [46:0] prod_t;

  // generator moduli and multipliers
  localparam val_t        MOD_A       = 31'd2147483563;
  localparam val_t        MOD_B       = 31'd2147483399;
  localparam logic [15:0] MUL_A       = 16'd40014;
  localparam logic [15:0] MUL_B       = 16'd40692;
  // 2^31 minus each modulus, used to fold the upper product bits back in
  localparam logic [7:0]  FOLD_A      = 8'd85;
  localparam logic [7:0]  FOLD_B      = 8'd249;
  localparam val_t        TOP_OUT     = 31'd2147483562;
  localparam val_t        INIT_SECOND = 31'd123456789;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_DRAW_MUL,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_t;

  // reduce a 47-bit product modulo a modulus just under 2^31
  function automatic val_t mod_fold(input prod_t prod, input logic [7:0] fold,
                                    input val_t modulus);
    logic [31:0] t;
    t = 32'(prod[46:31]) * 32'(fold) + 32'(prod[30:0]);
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[30:0];
  endfunction

endpackage

// ===== rtl/clsrng_if.sv =====
// ----------------------------------------------------------------------------
// clsrng_if
// Valid/ready channels for commands into and samples out of the RNG.
// ----------------------------------------------------------------------------
interface clsrng_req_if;
  import clsrng_pkg::*;

  logic valid;
  logic ready;
  logic cmd;
  val_t seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface clsrng_rsp_if;
  import clsrng_pkg::*;

  logic valid;
  logic ready;
  val_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/combined_lcg_shuffle_rng.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative generators behind a shuffle table in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per sample: cmd 0 draws, cmd 1 reseeds with
//   seed_value (0 taken as 1) and then draws. rsp returns one sample per
//   request, in 1..2147483562.
//   A draw runs from the accept through the multiply state, the fold together
//   with the shuffle table read, and the write-back through the table's
//   synchronous read and write ports; no new request is taken until the draw
//   is back in idle.
//   A reseed first runs TABLE_SIZE+8 generator steps, each a multiply state
//   and a fold state; the last TABLE_SIZE steps fill the table.
//   After reset the block is unseeded; its first draw reseeds with 1.
//   The shuffle table has no reset; every entry is filled by the first
//   reseed before any draw reads it.
//   The result sits in an output register. req.ready rises again while a
//   sample waits; if rsp stalls the next draw holds in its final step
//   until the output register frees.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
  parameter int unsigned TABLE_SIZE = clsrng_pkg::DEFAULT_TABLE_SIZE
) (
  input logic         clk,
  input logic         rst,
  clsrng_req_if.sink  req,
  clsrng_rsp_if.source rsp
);
  import clsrng_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned      IDX_W    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned      CNT_W    = $clog2(TABLE_SIZE + 8);
  localparam longint unsigned  BUCKET   = 64'd1 + 64'(TOP_OUT) / 64'(TABLE_SIZE);
  localparam int unsigned      RECIP_SH = 31 + $clog2(BUCKET);
  localparam longint unsigned  RECIP    = ((64'd1 << RECIP_SH) + BUCKET - 64'd1) / BUCKET;
  localparam logic [31:0]      RECIP_K  = RECIP[31:0];

  // sequencer and generator state
  state_t state, state_next;
  val_t   first_gen;
  val_t   second_gen;
  val_t   last_out;
  logic   out_valid;
  val_t   out_sample;

  // datapath registers
  prod_t             prod_a;
  prod_t             prod_b;
  logic [62:0]       prod_i;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  idx_reg;

  // shuffle table memory
  val_t             tbl [TABLE_SIZE];
  val_t             tbl_rdata;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  val_t             tbl_wdata;
  logic [IDX_W-1:0] rd_addr;

  logic             accept;
  logic             need_seed;
  logic             emit_ok;
  val_t             seed_eff;
  val_t             red_a;
  val_t             red_b;
  logic [62:0]      q_full;
  logic [IDX_W-1:0] idx_calc;
  logic [31:0]      diff;
  logic [31:0]      wrapped;
  val_t             new_out;

  // no request is taken while reset is held
  assign req.ready = (state == ST_IDLE) && !rst;
  assign rsp.valid = out_valid;
  assign rsp.sample = out_sample;

  assign accept    = req.valid && req.ready;
  assign need_seed = req.cmd || (first_gen == '0);
  assign emit_ok   = !out_valid || rsp.ready;
  assign seed_eff  = (req.cmd && (req.seed_value != '0)) ? req.seed_value : 31'd1;

  // generator folds off the registered products
  assign red_a = mod_fold(prod_a, FOLD_A, MOD_A);
  assign red_b = mod_fold(prod_b, FOLD_B, MOD_B);

  // table index by reciprocal multiply, wrapped to 0 if ever out of range
  assign q_full   = prod_i >> RECIP_SH;
  assign idx_calc = (q_full >= 63'(TABLE_SIZE)) ? '0 : q_full[IDX_W-1:0];

  // shuffled output: table entry minus second generator, wrapped into range
  assign diff    = {1'b0, tbl_rdata} - {1'b0, second_gen};
  assign wrapped = (diff[31] || (diff == '0)) ? (diff + {1'b0, TOP_OUT}) : diff;
  assign new_out = wrapped[30:0];

  // memory port control
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = idx_reg;
    tbl_wdata = first_gen;
    if (state == ST_SEED_RED) begin
      tbl_we    = (cnt < CNT_W'(TABLE_SIZE));
      tbl_waddr = cnt[IDX_W-1:0];
      tbl_wdata = red_a;
    end else if (state == ST_DRAW_WR) begin
      tbl_we = emit_ok;
    end
    rd_addr = (state == ST_DRAW_RD) ? idx_calc : idx_reg;
  end

  // table write and registered read; a draw reads before it writes back
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_seed ? ST_SEED_MUL : ST_DRAW_MUL;
        end
      end
      ST_SEED_MUL: state_next = ST_SEED_RED;
      ST_SEED_RED: state_next = (cnt == '0) ? ST_DRAW_MUL : ST_SEED_MUL;
      ST_DRAW_MUL: state_next = ST_DRAW_RD;
      ST_DRAW_RD:  state_next = ST_DRAW_WR;
      ST_DRAW_WR: begin
        if (emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // generator state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      first_gen  <= '0;
      second_gen <= INIT_SECOND;
      last_out   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_DRAW_WR) && emit_ok) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && need_seed) begin
            first_gen  <= seed_eff;
            second_gen <= seed_eff;
          end
        end
        ST_SEED_RED: begin
          first_gen <= red_a;
          if (cnt == '0) begin
            last_out <= red_a;
          end
        end
        ST_DRAW_RD: begin
          first_gen  <= red_a;
          second_gen <= red_b;
        end
        ST_DRAW_WR: begin
          if (emit_ok) begin
            last_out <= new_out;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // products, step counter, index and output payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cnt <= CNT_W'(TABLE_SIZE + 7);
      end
      ST_SEED_MUL: begin
        prod_a <= 47'(first_gen) * 47'(MUL_A);
      end
      ST_SEED_RED: begin
        cnt <= cnt - 1'b1;
      end
      ST_DRAW_MUL: begin
        prod_a <= 47'(first_gen) * 47'(MUL_A);
        prod_b <= 47'(second_gen) * 47'(MUL_B);
        prod_i <= 63'(last_out) * 63'(RECIP_K);
      end
      ST_DRAW_RD: begin
        idx_reg <= idx_calc;
      end
      ST_DRAW_WR: begin
        if (emit_ok) begin
          out_sample <= new_out;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `CLSRNG_ASSERT_NOW(a_sample_range, rsp.valid, (rsp.sample != '0) && (rsp.sample <= TOP_OUT))
  `CLSRNG_ASSERT_NOW(a_index_range, state == ST_DRAW_RD, q_full < 63'(TABLE_SIZE))
  `CLSRNG_ASSERT_NOW(a_fold_range, state == ST_SEED_RED, red_a < MOD_A)
  `CLSRNG_ASSERT_NEXT(a_hold_on_stall, (state == ST_DRAW_WR) && !emit_ok, state == ST_DRAW_WR)

endmodule
